// ----- src/triggered_sample_ramp_defines.svh -----
// Assertion macros for the triggered sample ramp block
`ifndef TRIGGERED_SAMPLE_RAMP_DEFINES_SVH
`define TRIGGERED_SAMPLE_RAMP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSRAMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSRAMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tsramp_pkg.sv -----
// Package: opcodes, state codes and controller/datapath interface types
`default_nettype none
package tsramp_pkg;

	localparam int FIELD_W   = 24;
	localparam int FRAC_BITS = 16;
	localparam int RAMP_W    = FRAC_BITS + 1;
	localparam int STEP_W    = $clog2(FRAC_BITS);

	localparam logic [RAMP_W-1:0] RAMP_ONE  = RAMP_W'(1) << FRAC_BITS;
	localparam logic [RAMP_W-1:0] RAMP_ZERO = '0;

	localparam logic [1:0] OP_SAMPLE  = 2'd0;
	localparam logic [1:0] OP_SET_LEN = 2'd1;
	localparam logic [1:0] OP_STOP    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	typedef struct packed {
		logic take;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic is_sample;
		logic div_needed;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- src/tsramp_dp.sv -----
// Datapath: ramp state, result registers and serial fraction divider
`default_nettype none
`include "triggered_sample_ramp_defines.svh"
module tsramp_dp #(
	parameter int COUNT_BITS = 24
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire                                   cfg_wdata,
	input  wire                                   [1:0] opcode,
	input  wire                                   trigger_level,
	input  wire  [tsramp_pkg::FIELD_W-1:0]        period_in,
	input  tsramp_pkg::dp_cmd_t                   cmd,
	output tsramp_pkg::dp_status_t                status,
	output logic [tsramp_pkg::FIELD_W-1:0]        count,
	output logic [tsramp_pkg::RAMP_W-1:0]         ramp
);

	localparam int FW = tsramp_pkg::FIELD_W;
	localparam int RW = tsramp_pkg::RAMP_W;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] length_q;
	logic                  last_level_q;
	logic                  loop_armed_q;
	logic                  loop_enable_q;

	logic [COUNT_BITS-1:0] out_count_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] divisor_q;
	logic [RW-1:0]         quot_q;

	logic [COUNT_BITS-1:0] period_c;
	logic                  is_sample;
	logic                  trig;
	logic [COUNT_BITS-1:0] cnt_eff;
	logic [COUNT_BITS-1:0] len_eff;
	logic                  below;
	logic [COUNT_BITS:0]   rem_shift;
	logic                  rem_ge;

	assign period_c  = COUNT_BITS'(period_in);
	assign is_sample = (opcode == tsramp_pkg::OP_SAMPLE);
	assign trig      = is_sample & trigger_level & ~last_level_q;
	assign cnt_eff   = trig ? '0 : count_q;
	assign len_eff   = trig ? period_c : length_q;
	assign below     = (cnt_eff < len_eff);

	assign status.is_sample  = is_sample;
	assign status.div_needed = below;

	assign rem_shift = {rem_q, 1'b0};
	assign rem_ge    = (rem_shift >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_enable_q <= 1'b0;
		end else if (cfg_we) begin
			loop_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			length_q     <= '0;
			last_level_q <= 1'b0;
			loop_armed_q <= 1'b0;
		end else if (cmd.take) begin
			case (opcode)
				tsramp_pkg::OP_SET_LEN: begin
					length_q <= period_c;
				end
				tsramp_pkg::OP_STOP: begin
					count_q <= length_q;
				end
				tsramp_pkg::OP_SAMPLE: begin
					length_q     <= len_eff;
					last_level_q <= trigger_level;
					if (below) begin
						count_q      <= cnt_eff + COUNT_BITS'(1);
						loop_armed_q <= loop_enable_q;
					end else if (loop_armed_q) begin
						count_q <= '0;
					end else begin
						count_q <= cnt_eff;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// load snapshot on a sample, then one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.take && is_sample) begin
			out_count_q <= cnt_eff;
			rem_q       <= cnt_eff;
			divisor_q   <= len_eff;
			if (below || len_eff == '0) begin
				quot_q <= tsramp_pkg::RAMP_ZERO;
			end else begin
				quot_q <= tsramp_pkg::RAMP_ONE;
			end
		end else if (cmd.step) begin
			quot_q <= {quot_q[RW-2:0], rem_ge};
			if (rem_ge) begin
				rem_q <= COUNT_BITS'(rem_shift - {1'b0, divisor_q});
			end else begin
				rem_q <= COUNT_BITS'(rem_shift);
			end
		end
	end

	assign count = FW'(out_count_q);
	assign ramp  = quot_q;

	`TSRAMP_ASSERT_NEXT(a_sample_count_advances, cmd.take && is_sample && below,
		count_q == $past(cnt_eff) + COUNT_BITS'(1), "count did not advance below length")
	`TSRAMP_ASSERT_NOW(a_rem_below_divisor, cmd.step, rem_q < divisor_q,
		"divider remainder not below divisor")

endmodule
`default_nettype wire

// ----- src/tsramp_ctrl.sv -----
// Controller: handshakes and divider step sequencing
`default_nettype none
`include "triggered_sample_ramp_defines.svh"
module tsramp_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire                      out_ready,
	input  tsramp_pkg::dp_status_t   status,
	output tsramp_pkg::dp_cmd_t      cmd
);

	localparam int SW = tsramp_pkg::STEP_W;
	localparam logic [SW-1:0] STEP_LAST = SW'(tsramp_pkg::FRAC_BITS - 1);

	tsramp_pkg::state_t state_q;
	logic [SW-1:0]      step_q;

	assign in_ready  = (state_q == tsramp_pkg::ST_IDLE);
	assign out_valid = (state_q == tsramp_pkg::ST_OUT);
	assign cmd.take  = in_valid & in_ready;
	assign cmd.step  = (state_q == tsramp_pkg::ST_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsramp_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				tsramp_pkg::ST_IDLE: begin
					step_q <= '0;
					if (cmd.take && status.is_sample) begin
						if (status.div_needed) begin
							state_q <= tsramp_pkg::ST_DIV;
						end else begin
							state_q <= tsramp_pkg::ST_OUT;
						end
					end
				end
				tsramp_pkg::ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == STEP_LAST) begin
						state_q <= tsramp_pkg::ST_OUT;
					end
				end
				tsramp_pkg::ST_OUT: begin
					if (out_ready) begin
						state_q <= tsramp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tsramp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	`TSRAMP_ASSERT_NOW(a_no_accept_during_result, out_valid, !in_ready,
		"input taken while result pending")
	`TSRAMP_ASSERT_NEXT(a_div_ends_in_out, cmd.step && step_q == STEP_LAST, out_valid,
		"divider finished without presenting result")
	`TSRAMP_ASSERT_NEXT(a_sample_starts_div, cmd.take && status.is_sample && status.div_needed,
		cmd.step && step_q == '0, "fraction division did not start")

endmodule
`default_nettype wire

// ----- src/triggered_sample_ramp.sv -----
// A set, stop or unused opcode is taken while idle and gives no result.
// A sample gives its result in the cycle after transfer at count >= length,
// else after the 16-step serial fraction divider has run.
// Throughput: one item in flight; the next transfer waits until the result is taken.
// Reset: arst_n asynchronously clears count, length, trigger history,
// loop arm and loop enable, and returns the controller to idle.
`default_nettype none
module triggered_sample_ramp #(
	parameter int COUNT_BITS = 24
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire                                cfg_wdata,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [1:0]                         opcode,
	input  wire                                trigger_level,
	input  wire  [tsramp_pkg::FIELD_W-1:0]     period_in,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [tsramp_pkg::FIELD_W-1:0]     count,
	output logic [tsramp_pkg::RAMP_W-1:0]      ramp
);

	tsramp_pkg::dp_cmd_t    cmd;
	tsramp_pkg::dp_status_t status;

	tsramp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tsramp_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.opcode        (opcode),
		.trigger_level (trigger_level),
		.period_in     (period_in),
		.cmd           (cmd),
		.status        (status),
		.count         (count),
		.ramp          (ramp)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for triggered_sample_ramp: directed table, then randomized traffic checked by a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 285;
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES = 250;
	localparam logic [tsramp_pkg::FIELD_W-1:0] PERIOD_MAX = '1;

	typedef struct packed {
		logic [tsramp_pkg::FIELD_W-1:0] count;
		logic [tsramp_pkg::RAMP_W-1:0]  ramp;
	} ramp_point_t;

	typedef struct packed {
		logic                           loop_en;
		logic [1:0]                     op;
		logic                           lvl;
		logic [tsramp_pkg::FIELD_W-1:0] per;
		logic                           has_exp;
		ramp_point_t                    want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = tsramp_pkg::OP_SAMPLE;
	logic trigger_level = 1'b0;
	logic [tsramp_pkg::FIELD_W-1:0] period_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [tsramp_pkg::FIELD_W-1:0] count;
	logic [tsramp_pkg::RAMP_W-1:0] ramp;

	logic [tsramp_pkg::FIELD_W-1:0] cnt_m = '0;
	logic [tsramp_pkg::FIELD_W-1:0] len_m = '0;
	logic lvl_m = 1'b0;
	logic armed_m = 1'b0;
	logic loop_m = 1'b0;

	ramp_point_t ramp_points_q[$];
	int n_errors = 0;
	int mode = 0;
	int results_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	stim_row_t dir_rows [25] = '{
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b0, 24'd5,      1'b1, '{24'd0, tsramp_pkg::RAMP_ZERO}},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd4,      1'b1, '{24'd0, tsramp_pkg::RAMP_ZERO}},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd4,      1'b0, '0},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b0, '0},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b0, '0},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b1, '{24'd4, tsramp_pkg::RAMP_ONE}},
		'{1'b0, tsramp_pkg::OP_SET_LEN, 1'b1, 24'd2,      1'b0, '0},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b1, '{24'd4, tsramp_pkg::RAMP_ONE}},
		'{1'b0, OP_UNUSED,              1'b0, PERIOD_MAX, 1'b0, '0},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b0, PERIOD_MAX, 1'b1, '{24'd4, tsramp_pkg::RAMP_ONE}},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, PERIOD_MAX, 1'b1, '{24'd0, tsramp_pkg::RAMP_ZERO}},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b1, '{24'd1, tsramp_pkg::RAMP_ZERO}},
		'{1'b0, tsramp_pkg::OP_STOP,    1'b0, 24'd0,      1'b0, '0},
		'{1'b0, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b1,
			'{PERIOD_MAX, tsramp_pkg::RAMP_ONE}},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b0, 24'd0,      1'b1,
			'{PERIOD_MAX, tsramp_pkg::RAMP_ONE}},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd3,      1'b1, '{24'd0, tsramp_pkg::RAMP_ZERO}},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd3,      1'b0, '0},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd3,      1'b0, '0},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd3,      1'b1, '{24'd3, tsramp_pkg::RAMP_ONE}},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd3,      1'b1, '{24'd0, tsramp_pkg::RAMP_ZERO}},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b0, 24'd0,      1'b0, '0},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b1, '{24'd0, tsramp_pkg::RAMP_ZERO}},
		'{1'b1, tsramp_pkg::OP_SET_LEN, 1'b0, 24'h800000, 1'b0, '0},
		'{1'b1, tsramp_pkg::OP_STOP,    1'b1, 24'd0,      1'b0, '0},
		'{1'b1, tsramp_pkg::OP_SAMPLE,  1'b1, 24'd0,      1'b1,
			'{24'h800000, tsramp_pkg::RAMP_ONE}}
	};

	triggered_sample_ramp dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.trigger_level (trigger_level),
		.period_in     (period_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.count         (count),
		.ramp          (ramp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit ramp_predict(input logic [1:0] op, input logic lvl,
			input logic [tsramp_pkg::FIELD_W-1:0] per, output ramp_point_t pt);
		logic [63:0] q;
		pt = '0;
		if (op == tsramp_pkg::OP_SET_LEN) begin
			len_m = per;
			return 1'b0;
		end
		if (op == tsramp_pkg::OP_STOP) begin
			cnt_m = len_m;
			return 1'b0;
		end
		if (op != tsramp_pkg::OP_SAMPLE)
			return 1'b0;
		if (lvl && !lvl_m) begin
			cnt_m = '0;
			len_m = per;
		end
		pt.count = cnt_m;
		if (len_m == '0) begin
			pt.ramp = tsramp_pkg::RAMP_ZERO;
		end else begin
			q = (64'(cnt_m) << tsramp_pkg::FRAC_BITS) / 64'(len_m);
			pt.ramp = (q > 64'(tsramp_pkg::RAMP_ONE)) ? tsramp_pkg::RAMP_ONE :
				q[tsramp_pkg::RAMP_W-1:0];
		end
		if (cnt_m < len_m) begin
			cnt_m = cnt_m + 1'b1;
			armed_m = loop_m;
		end else if (armed_m) begin
			cnt_m = '0;
		end
		lvl_m = lvl;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("tb_top mismatch: %s", msg);
		n_errors++;
	endtask

	task automatic push_item(input logic [1:0] op, input logic lvl,
			input logic [tsramp_pkg::FIELD_W-1:0] per,
			input logic has_exp, input ramp_point_t want);
		int snd_pct;
		ramp_point_t pt;
		snd_pct = (mode == 0) ? 21 : (mode == 1) ? 66 : 0;
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		trigger_level <= lvl;
		period_in <= per;
		do @(posedge clk); while (!in_ready);
		if (ramp_predict(op, lvl, per, pt))
			ramp_points_q.push_back(has_exp ? want : pt);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (ramp_points_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_loop_enable(input logic v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		loop_m = v;
	endtask

	always @(posedge clk) begin
		int rcv_pct;
		ramp_point_t exp_pt;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (results_seen == HOLD_AT_RESULT)
				hold_left = HOLD_CYCLES;
			if (ramp_points_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result count=%0d ramp=%0d", count, ramp));
			end else begin
				exp_pt = ramp_points_q.pop_front();
				if (count !== exp_pt.count)
					report_mismatch($sformatf("count got %0d want %0d", count, exp_pt.count));
				if (ramp !== exp_pt.ramp)
					report_mismatch($sformatf("ramp got %0d want %0d", ramp, exp_pt.ramp));
			end
		end
		rcv_pct = (mode == 0) ? 66 : (mode == 1) ? 21 : 0;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		logic [1:0] op;
		logic lvl;
		logic [tsramp_pkg::FIELD_W-1:0] per;
		int r;
		int n;
		lvl = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		mode = 0;
		write_loop_enable(dir_rows[0].loop_en);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].loop_en != loop_m)
				write_loop_enable(dir_rows[i].loop_en);
			push_item(dir_rows[i].op, dir_rows[i].lvl, dir_rows[i].per,
				dir_rows[i].has_exp, dir_rows[i].want);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			write_loop_enable(ph[0]);
			mode = ph / 2;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				r = $urandom_range(99);
				op = (r < 74) ? tsramp_pkg::OP_SAMPLE :
					(r < 84) ? tsramp_pkg::OP_SET_LEN :
					(r < 92) ? tsramp_pkg::OP_STOP : OP_UNUSED;
				if ($urandom_range(99) < 12)
					lvl = !lvl;
				r = $urandom_range(99);
				if (r < 55)
					per = tsramp_pkg::FIELD_W'($urandom_range(8));
				else if (r < 75)
					per = tsramp_pkg::FIELD_W'($urandom_range(400, 9));
				else if (r < 85)
					per = tsramp_pkg::FIELD_W'($urandom);
				else if (r < 92)
					per = '0;
				else
					per = PERIOD_MAX;
				push_item(op, lvl, per, 1'b0, '0);
				n++;
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (n_errors == 0 && ramp_points_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
`default_nettype wire
